// File: design/bldr_pkg.sv
`default_nettype none

package bldr_pkg;

   // Brightness range
   localparam int MAX_LEVEL = 255;
   localparam logic [7:0] TOP_LEVEL = (MAX_LEVEL > 255) ? 8'd255 : 8'(MAX_LEVEL);

   // Field and register widths
   localparam int EVENT_W  = 3;
   localparam int LEVEL_W  = 8;
   localparam int PERIOD_W = 16;
   localparam int COUNT_W  = 16;
   localparam int CSR_IDX_W = 1;

   // Reset values of the period registers
   localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd10;
   localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd100;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_PERIOD = 1'd1;

   // Decoded button events
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE     = 3'd0,
      EV_DOUBLE   = 3'd1,
      EV_SINGLE   = 3'd2,
      EV_LONG     = 3'd3,
      EV_RELEASED = 3'd4
   } event_type;

   // One result item
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               fast_active;
      logic               slow_active;
      logic               dimming;
   } result_type;

endpackage

`default_nettype wire

// File: design/bldr_core.sv
`default_nettype none

module bldr_core import bldr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PERIOD_W-1:0]  csr_wdata,
   input  wire logic                 step_en,
   input  wire logic [EVENT_W-1:0]   button_event,
   input  wire logic                 tick,
   output result_type                result
);

   logic [PERIOD_W-1:0] fast_period_ff;
   logic [PERIOD_W-1:0] slow_period_ff;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                fast_ff, fast_in;
   logic                slow_ff, slow_in;
   logic                down_ff, down_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Apply the event, then the fast and slow ramp updates when tick is set
   always_comb begin
      logic [LEVEL_W-1:0] lvl;
      logic               ff;
      logic               sf;
      logic               df;
      logic [COUNT_W-1:0] cnt;
      lvl = level_ff;
      ff  = fast_ff;
      sf  = slow_ff;
      df  = down_ff;
      cnt = count_ff;

      case (button_event)
         EV_DOUBLE: begin
            lvl = TOP_LEVEL;
            ff  = 1'b0;
            sf  = 1'b0;
         end
         EV_SINGLE: begin
            ff = !ff;
            if (lvl == TOP_LEVEL) begin
               df = 1'b1;
            end else if (lvl == '0) begin
               df = 1'b0;
            end
         end
         EV_LONG: begin
            sf = 1'b1;
         end
         EV_RELEASED: begin
            sf = 1'b0;
         end
         default: begin
         end
      endcase

      // Fast ramp: step after its period, stop at either end
      if (tick && ff) begin
         if ((df && lvl == '0) || (!df && lvl == TOP_LEVEL)) begin
            ff = 1'b0;
         end else if (cnt > fast_period_ff) begin
            lvl = df ? lvl - 1'b1 : lvl + 1'b1;
            cnt = '0;
         end else begin
            cnt = cnt + 1'b1;
         end
      end

      // Slow ramp: step after its period, reverse at either end
      if (tick && sf) begin
         if (df && lvl == '0) begin
            df = 1'b0;
         end else if (!df && lvl == TOP_LEVEL) begin
            df = 1'b1;
         end else if (cnt > slow_period_ff) begin
            lvl = df ? lvl - 1'b1 : lvl + 1'b1;
            cnt = '0;
         end else begin
            cnt = cnt + 1'b1;
         end
      end

      level_in = lvl;
      fast_in  = ff;
      slow_in  = sf;
      down_in  = df;
      count_in = cnt;
   end

   // Hold configuration and ramp state; advance state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= FAST_PERIOD_RST;
         slow_period_ff <= SLOW_PERIOD_RST;
         level_ff       <= '0;
         fast_ff        <= 1'b0;
         slow_ff        <= 1'b0;
         down_ff        <= 1'b0;
         count_ff       <= '0;
      end else begin
         if (csr_write && csr_index == CSR_FAST_PERIOD) begin
            fast_period_ff <= csr_wdata;
         end
         if (csr_write && csr_index == CSR_SLOW_PERIOD) begin
            slow_period_ff <= csr_wdata;
         end
         if (step_en) begin
            level_ff <= level_in;
            fast_ff  <= fast_in;
            slow_ff  <= slow_in;
            down_ff  <= down_in;
            count_ff <= count_in;
         end
      end
   end

   assign result.level       = level_in;
   assign result.fast_active = fast_in;
   assign result.slow_active = slow_in;
   assign result.dimming     = down_in;

endmodule

`default_nettype wire

// File: design/bldr_outbuf.sv
`default_nettype none

module bldr_outbuf import bldr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            full,
   output logic            out_valid,
   input  wire logic       out_stall,
   output result_type      out_data
);

   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;
   logic       out_take;

   assign out_take = out_valid_ff && !out_stall;

   // Output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Move payload: skid drains first, new transfers fill behind
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         if (push) begin
            out_data_ff <= push_data;
         end
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// File: design/button_led_dimmer_ramp.sv
// Button-driven LED dimmer with a fast ramp and a slow ramp.
// Request channel (req_valid / req_stall) carries one decoded button event
// and a tick flag; each transfer yields exactly one response on the rsp_
// channel (rsp_valid / rsp_stall) with the level and ramp flags after the step.
// A step result is registered in the output register, or in the skid entry
// while a response waits. Throughput: one request per cycle while req_stall is
// low; each step (event, fast ramp, slow ramp) is one pass of logic.
// The output register has one skid entry behind it, so a request is taken
// while a response waits; req_stall rises only when both are occupied.
// When the receiver stalls, the held response stays unchanged on rsp_ ports.
// csr_write with csr_index 0 sets the fast period, 1 the slow period; write
// only while idle. Synchronous reset clears level, flags, counter and both
// buffer entries, and restores periods to 10 and 100.
`default_nettype none

module button_led_dimmer_ramp import bldr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PERIOD_W-1:0]  csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [EVENT_W-1:0]   req_button_event,
   input  wire logic                 req_tick,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [LEVEL_W-1:0]        rsp_level,
   output logic                      rsp_fast_active,
   output logic                      rsp_slow_active,
   output logic                      rsp_dimming
);

   logic       buf_full;
   logic       req_xfer;
   result_type step_result;
   result_type rsp_data;

   assign req_stall = buf_full;
   assign req_xfer  = req_valid && !buf_full;

   bldr_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .step_en      (req_xfer),
      .button_event (req_button_event),
      .tick         (req_tick),
      .result       (step_result)
   );

   bldr_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (step_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_level       = rsp_data.level;
   assign rsp_fast_active = rsp_data.fast_active;
   assign rsp_slow_active = rsp_data.slow_active;
   assign rsp_dimming     = rsp_data.dimming;

endmodule

`default_nettype wire

// File: verif/tb_button_led_dimmer_ramp.sv
`timescale 1ns / 1ps

module tb_button_led_dimmer_ramp;
   import bldr_pkg::*;

   localparam int IDLE_PCT       = 19;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int MAX_REPORTS    = 10;

   // Codes outside the defined events; the block treats them as no event
   localparam logic [EVENT_W-1:0] EV_UNUSED_FIRST = 3'd5;
   localparam logic [EVENT_W-1:0] EV_UNUSED_LAST  = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PERIOD_W-1:0]  csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [EVENT_W-1:0]   req_button_event = EV_NONE;
   logic                 req_tick = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]   rsp_level;
   logic                 rsp_fast_active;
   logic                 rsp_slow_active;
   logic                 rsp_dimming;

   // Dimmer state as the testbench tracks it
   logic [LEVEL_W-1:0]  model_level;
   logic                model_fast;
   logic                model_slow;
   logic                model_down;
   logic [COUNT_W-1:0]  model_count;
   logic [PERIOD_W-1:0] model_fast_period;
   logic [PERIOD_W-1:0] model_slow_period;

   result_type pending_levels[$];
   result_type rsp_seen;
   result_type rsp_want;
   bit         quiet_phase = 1'b0;
   int         mismatch_count = 0;
   int         stuck_cycles = 0;

   button_led_dimmer_ramp DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_event (req_button_event),
      .req_tick         (req_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level        (rsp_level),
      .rsp_fast_active  (rsp_fast_active),
      .rsp_slow_active  (rsp_slow_active),
      .rsp_dimming      (rsp_dimming)
   );

   always #1 clock = ~clock;

   // Test the shared counter against a period, then advance it
   function automatic bit ramp_step_due(input logic [PERIOD_W-1:0] period);
      bit due;
      due = (model_count > period);
      model_count = model_count + 1'b1;
      return due;
   endfunction

   // Apply one event and optional tick, queue the resulting dimmer state
   task automatic predict_dimmer(input logic [EVENT_W-1:0] ev, input logic tk);
      result_type r;
      if (ev == EV_DOUBLE) begin
         model_level = TOP_LEVEL;
         model_fast  = 1'b0;
         model_slow  = 1'b0;
      end else if (ev == EV_SINGLE) begin
         model_fast = !model_fast;
         if (model_level == TOP_LEVEL)
            model_down = 1'b1;
         else if (model_level == '0)
            model_down = 1'b0;
      end else if (ev == EV_LONG) begin
         model_slow = 1'b1;
      end else if (ev == EV_RELEASED) begin
         model_slow = 1'b0;
      end

      if (tk) begin
         // Fast ramp first: step toward the end, stop there
         if (model_fast) begin
            if (model_down) begin
               if (model_level != '0) begin
                  if (ramp_step_due(model_fast_period)) begin
                     model_level = model_level - 1'b1;
                     model_count = '0;
                  end
               end else begin
                  model_fast = 1'b0;
               end
            end else begin
               if (model_level < TOP_LEVEL) begin
                  if (ramp_step_due(model_fast_period)) begin
                     model_level = model_level + 1'b1;
                     model_count = '0;
                  end
               end else begin
                  model_fast = 1'b0;
               end
            end
         end
         // Slow ramp sees the fast ramp's result and reverses at the ends
         if (model_slow) begin
            if (model_down) begin
               if (model_level != '0) begin
                  if (ramp_step_due(model_slow_period)) begin
                     model_level = model_level - 1'b1;
                     model_count = '0;
                  end
               end else begin
                  model_down = 1'b0;
               end
            end else begin
               if (model_level < TOP_LEVEL) begin
                  if (ramp_step_due(model_slow_period)) begin
                     model_level = model_level + 1'b1;
                     model_count = '0;
                  end
               end else begin
                  model_down = 1'b1;
               end
            end
         end
      end

      r.level       = model_level;
      r.fast_active = model_fast;
      r.slow_active = model_slow;
      r.dimming     = model_down;
      pending_levels.push_back(r);
   endtask

   // Present one button item, hold it until the transfer, then predict
   task automatic send_button(input logic [EVENT_W-1:0] ev, input logic tk);
      while (!quiet_phase && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_button_event <= ev;
      req_tick         <= tk;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      predict_dimmer(ev, tk);
   endtask

   // Drop valid and wait until every expected response has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both periods while the block is idle
   task automatic set_periods(input logic [PERIOD_W-1:0] fast_p,
                              input logic [PERIOD_W-1:0] slow_p);
      settle();
      csr_write <= 1'b1;
      csr_index <= CSR_FAST_PERIOD;
      csr_wdata <= fast_p;
      @(posedge clock);
      model_fast_period = fast_p;
      csr_index <= CSR_SLOW_PERIOD;
      csr_wdata <= slow_p;
      @(posedge clock);
      model_slow_period = slow_p;
      csr_write <= 1'b0;
   endtask

   // Mostly ticks with no event; rate_pct sets how often an event appears
   function automatic logic [EVENT_W-1:0] pick_event(input int rate_pct);
      int r;
      if ($urandom_range(99) >= rate_pct)
         return EV_NONE;
      r = $urandom_range(9);
      case (r)
         0, 1, 2: return EV_SINGLE;
         3:       return EV_DOUBLE;
         4, 5:    return EV_LONG;
         6, 7:    return EV_RELEASED;
         default: return EV_UNUSED_FIRST +
                         EVENT_W'($urandom_range(EV_UNUSED_LAST - EV_UNUSED_FIRST));
      endcase
   endfunction

   task automatic run_random(input int count, input int rate_pct);
      repeat (count) send_button(pick_event(rate_pct), $urandom_range(99) < 85);
   endtask

   // Default periods: the fast ramp needs twelve ticks for its first step
   task automatic test_reset_periods();
      send_button(EV_SINGLE, 1'b1);
      repeat (12) send_button(EV_NONE, 1'b1);
      send_button(EV_SINGLE, 1'b0);
   endtask

   // Each event code, both ramps on one counter, unused codes ignored
   task automatic test_event_codes();
      set_periods('0, '0);
      send_button(EV_DOUBLE, 1'b1);
      send_button(EV_SINGLE, 1'b1);
      repeat (3) send_button(EV_NONE, 1'b1);
      send_button(EV_LONG, 1'b1);
      repeat (3) send_button(EV_NONE, 1'b1);
      send_button(EV_RELEASED, 1'b0);
      send_button(EV_DOUBLE, 1'b0);
      for (int e = EV_UNUSED_FIRST; e <= EV_UNUSED_LAST; e++)
         send_button(e[EVENT_W-1:0], e[0]);
      send_button(EV_LONG, 1'b1);
      send_button(EV_NONE, 1'b0);
   endtask

   // Both ramps downward from the top with no idling, through both ends
   task automatic test_dual_ramp_sweep();
      set_periods('0, '0);
      quiet_phase = 1'b1;
      send_button(EV_DOUBLE, 1'b0);
      send_button(EV_SINGLE, 1'b1);
      send_button(EV_LONG, 1'b1);
      run_random(400, 3);
      quiet_phase = 1'b0;
   endtask

   // Random traffic across period settings, from 0 up to 65534
   task automatic test_random_periods();
      set_periods('0, 16'd65534);
      send_button(EV_SINGLE, 1'b1);
      run_random(150, 10);
      set_periods(16'd65534, 16'd1);
      send_button(EV_DOUBLE, 1'b1);
      send_button(EV_LONG, 1'b1);
      run_random(150, 6);
      set_periods(16'd2, '0);
      send_button(EV_LONG, 1'b1);
      run_random(150, 8);
      set_periods(PERIOD_W'($urandom_range(15)), PERIOD_W'($urandom_range(15)));
      run_random(150, 10);
      set_periods(PERIOD_W'($urandom_range(65534)), PERIOD_W'($urandom_range(65534)));
      run_random(100, 20);
   endtask

   // Receiver stalls at random outside the quiet stretch
   always @(posedge clock)
      rsp_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_seen = {rsp_level, rsp_fast_active, rsp_slow_active, rsp_dimming};
         if (pending_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: level %0d fast %b slow %b dim %b",
                        rsp_seen.level, rsp_seen.fast_active, rsp_seen.slow_active,
                        rsp_seen.dimming);
         end else begin
            rsp_want = pending_levels.pop_front();
            if (rsp_seen.level !== rsp_want.level ||
                rsp_seen.fast_active !== rsp_want.fast_active ||
                rsp_seen.slow_active !== rsp_want.slow_active ||
                rsp_seen.dimming !== rsp_want.dimming) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: level %0d/%0d fast %b/%b slow %b/%b dim %b/%b (exp/act)",
                           rsp_want.level, rsp_seen.level,
                           rsp_want.fast_active, rsp_seen.fast_active,
                           rsp_want.slow_active, rsp_seen.slow_active,
                           rsp_want.dimming, rsp_seen.dimming);
            end
         end
      end
   end

   // End the run when no transfer happens on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      model_level       = '0;
      model_fast        = 1'b0;
      model_slow        = 1'b0;
      model_down        = 1'b0;
      model_count       = '0;
      model_fast_period = FAST_PERIOD_RST;
      model_slow_period = SLOW_PERIOD_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_periods();
      test_event_codes();
      test_dual_ramp_sweep();
      test_random_periods();
      settle();

      if (mismatch_count == 0 && pending_levels.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
